@@ src/brf_pkg.sv @@
// brf_pkg: shared types, constants and index helpers for the byte ring FIFO.
// Used by brf_out and byte_ring_fifo_with_line_read_core; no dependencies.
`default_nettype none
package brf_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = 7;
	localparam int BYTE_W = 8;

	typedef logic [1:0]        code_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [BYTE_W-1:0] byte_t;

	localparam code_t CMD_WRITE = 2'd0;
	localparam code_t CMD_READ  = 2'd1;
	localparam code_t CMD_LINE  = 2'd2;
	localparam code_t CMD_QUERY = 2'd3;

	localparam code_t STS_WR_OK   = 2'd0;
	localparam code_t STS_WR_FULL = 2'd1;
	localparam code_t STS_BYTE    = 2'd2;
	localparam code_t STS_FREE    = 2'd3;

	localparam idx_t LAST_IDX  = idx_t'(DEPTH - 1);
	localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);

	typedef struct packed {
		code_t status;
		byte_t read_byte;
		cnt_t  free_space;
		logic  last;
	} res_t;

	function automatic idx_t next_idx(input idx_t idx);
		next_idx = (idx == LAST_IDX) ? '0 : idx_t'(idx + idx_t'(1));
	endfunction

	function automatic cnt_t used_cnt(input idx_t rd, input idx_t wr, input logic empty);
		cnt_t rd_c;
		cnt_t wr_c;
		rd_c = cnt_t'(rd);
		wr_c = cnt_t'(wr);
		if (wr == rd)
			used_cnt = empty ? '0 : DEPTH_CNT;
		else if (wr > rd)
			used_cnt = cnt_t'(wr_c - rd_c);
		else
			used_cnt = cnt_t'(DEPTH_CNT - rd_c + wr_c);
	endfunction

endpackage
`default_nettype wire

@@ src/byte_ring_fifo_with_line_read_core.sv @@
// byte_ring_fifo_with_line_read_core: top level of the circular byte FIFO.
// Depends on brf_pkg, brf_ram and brf_out.
//
// A 64-entry byte ring in one synchronous RAM. A write or a free-space query
// gives one result; writes and queries can follow each other every cycle
// while the output register has space. A read or line read on an empty ring,
// or a read with zero count, gives no result. A read of N bytes holds the
// input while it runs: the RAM read data is registered, then one byte per
// cycle, set by the single RAM read port, unless the output stalls. A line read
// stops after the first byte equal to the delimiter register, or after the last
// stored byte; the RAM fetch runs one byte ahead and is cut off when the
// delimiter shows up. No input request is taken while a read is in progress.
`default_nettype none
module byte_ring_fifo_with_line_read_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [7:0]  cfg_wr_data,  // [7:0] line_delimiter
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,      // [7:0] write_byte, [14:8] byte_count, [15] zero
	input  wire  [1:0]  s_tuser,      // [1:0] command
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,      // [7:0] read_byte, [14:8] free_space, [15] zero
	output logic [1:0]  m_tuser,      // [1:0] status
	output logic        m_tlast
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RD   = 1'b1;

	logic                 state_q;
	brf_pkg::idx_t        rd_q;
	brf_pkg::idx_t        wr_q;
	logic                 empty_q;
	brf_pkg::byte_t       delim_q;
	logic                 line_q;
	brf_pkg::idx_t        fp_q;
	brf_pkg::cnt_t        left_q;
	logic                 v_s1;
	logic                 tag_s1;

	brf_pkg::code_t       cmd;
	brf_pkg::byte_t       wbyte;
	brf_pkg::cnt_t        bcount;
	brf_pkg::cnt_t        used;
	brf_pkg::cnt_t        rd_n;
	logic                 full;
	logic                 acc;
	logic                 out_space;
	logic                 s1_move;
	logic                 is_delim;
	logic                 s1_last;
	logic                 issue;
	logic                 ram_we;
	brf_pkg::byte_t       rdata;
	brf_pkg::idx_t        rd_next;
	logic                 push;
	brf_pkg::res_t        res;
	logic [brf_pkg::CNT_W:0] inflight;

	assign cmd    = s_tuser;
	assign wbyte  = s_tdata[7:0];
	assign bcount = s_tdata[14:8];

	assign used     = brf_pkg::used_cnt(rd_q, wr_q, empty_q);
	assign full     = !empty_q && (rd_q == wr_q);
	assign rd_n     = (bcount < used) ? bcount : used;
	assign s_tready = (state_q == ST_IDLE) && out_space;
	assign acc      = s_tvalid && s_tready;
	assign ram_we   = acc && (cmd == brf_pkg::CMD_WRITE) && !full;

	assign s1_move  = v_s1 && out_space;
	assign is_delim = line_q && (rdata == delim_q);
	assign s1_last  = tag_s1 || is_delim;
	assign issue    = (state_q == ST_RD) && (left_q != '0) && (!v_s1 || s1_move)
			&& !(s1_move && is_delim);
	assign rd_next  = brf_pkg::next_idx(rd_q);
	assign inflight = {1'b0, left_q} + {{brf_pkg::CNT_W{1'b0}}, v_s1};

	brf_ram #(
		.WIDTH(brf_pkg::BYTE_W),
		.DEPTH(brf_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_q),
		.wdata (wbyte),
		.re    (issue),
		.raddr (fp_q),
		.rdata (rdata)
	);

	always_comb begin
		push           = 1'b0;
		res.status     = brf_pkg::STS_BYTE;
		res.read_byte  = '0;
		res.free_space = '0;
		res.last       = 1'b1;
		if (s1_move) begin
			push          = 1'b1;
			res.read_byte = rdata;
			res.last      = s1_last;
		end else if (acc) begin
			unique case (cmd)
				brf_pkg::CMD_WRITE: begin
					push       = 1'b1;
					res.status = full ? brf_pkg::STS_WR_FULL : brf_pkg::STS_WR_OK;
				end
				brf_pkg::CMD_QUERY: begin
					push           = 1'b1;
					res.status     = brf_pkg::STS_FREE;
					res.free_space = brf_pkg::cnt_t'(brf_pkg::DEPTH_CNT - used);
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	brf_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res      (res),
		.space    (out_space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= 8'd10;
		end else if (cfg_wr_en) begin
			delim_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_q    <= '0;
			wr_q    <= '0;
			empty_q <= 1'b1;
			line_q  <= 1'b0;
			fp_q    <= '0;
			left_q  <= '0;
			v_s1    <= 1'b0;
			tag_s1  <= 1'b0;
		end else begin
			if (ram_we) begin
				wr_q    <= brf_pkg::next_idx(wr_q);
				empty_q <= 1'b0;
			end
			if (acc && (cmd == brf_pkg::CMD_READ) && (rd_n != '0)) begin
				state_q <= ST_RD;
				left_q  <= rd_n;
				fp_q    <= rd_q;
				line_q  <= 1'b0;
			end
			if (acc && (cmd == brf_pkg::CMD_LINE) && (used != '0)) begin
				state_q <= ST_RD;
				left_q  <= used;
				fp_q    <= rd_q;
				line_q  <= 1'b1;
			end
			if (issue) begin
				fp_q   <= brf_pkg::next_idx(fp_q);
				left_q <= brf_pkg::cnt_t'(left_q - brf_pkg::cnt_t'(1));
				v_s1   <= 1'b1;
				tag_s1 <= (left_q == brf_pkg::cnt_t'(1));
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move) begin
				rd_q <= rd_next;
				if (rd_next == wr_q) begin
					empty_q <= 1'b1;
				end
				if (s1_last) begin
					state_q <= ST_IDLE;
					left_q  <= '0;
				end
			end
		end
	end

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (rd_q == wr_q))
		else $error("empty flag set with unequal indices");

	a_fetch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (inflight <= {1'b0, used}))
		else $error("fetch runs past stored bytes");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == ST_IDLE) && !v_s1))
		else $error("RAM write during a read");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && s1_last) |=> ((state_q == ST_IDLE) && !v_s1))
		else $error("read did not end after last byte");

endmodule
`default_nettype wire

@@ src/brf_ram.sv @@
// brf_ram: generic single-write, single-read RAM with registered read data.
// Read data holds until the next read enable. No dependencies.
`default_nettype none
module brf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                                     clk,
	input  wire                                     we,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                         wdata,
	input  wire                                     re,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ src/brf_out.sv @@
// brf_out: output register for result requests of the byte ring FIFO.
// Depends on brf_pkg (res_t).
`default_nettype none
module brf_out (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  brf_pkg::res_t  res,
	output logic           space,
	output logic           m_tvalid,
	input  wire            m_tready,
	output logic [15:0]    m_tdata,  // [7:0] read_byte, [14:8] free_space, [15] zero
	output logic [1:0]     m_tuser,  // [1:0] status
	output logic           m_tlast
);

	logic          valid_q;
	brf_pkg::res_t res_q;

	assign space = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (space && push) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, res_q.free_space, res_q.read_byte};
	assign m_tuser  = res_q.status;
	assign m_tlast  = res_q.last;

endmodule
`default_nettype wire

@@ bench/tb_byte_ring_fifo_with_line_read_core.sv @@
// Testbench for byte_ring_fifo_with_line_read_core: directed table, full-ring pressure
// and random phases under several delimiters, checked against an in-bench ring model.
// Depends on brf_pkg and the core RTL.
`default_nettype none
module tb_byte_ring_fifo_with_line_read_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRED           = -1;
	localparam int N_DIR          = 24;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYC     = 16;

	typedef struct {
		brf_pkg::code_t cmd;
		brf_pkg::byte_t wr_byte;
		brf_pkg::cnt_t  count;
		int             exp_n;
		brf_pkg::res_t  exp_res;
	} step_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [7:0]  cfg_wr_data = 8'h00;
	logic        s_tvalid    = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata     = '0;
	logic [1:0]  s_tuser     = '0;
	logic        m_tvalid;
	logic        m_tready    = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// per-request override of the prediction, driven with the request
	int            tab_n   = PRED;
	brf_pkg::res_t tab_res = '0;

	logic hold_req = 1'b0;
	logic no_gaps  = 1'b0;
	int   err_cnt  = 0;
	int   idle_cyc = 0;

	// ring model
	brf_pkg::byte_t ring_mem [brf_pkg::DEPTH];
	brf_pkg::idx_t  rd_pos     = '0;
	brf_pkg::idx_t  wr_pos     = '0;
	logic           ring_empty = 1'b1;
	brf_pkg::byte_t delim      = 8'h0A;
	brf_pkg::res_t  step_resp [$];
	brf_pkg::res_t  pending_resp [$];

	step_t dir_tab [N_DIR];

	byte_ring_fifo_with_line_read_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic brf_pkg::idx_t ring_next(brf_pkg::idx_t p);
		return (int'(p) == brf_pkg::DEPTH - 1) ? '0 : brf_pkg::idx_t'(int'(p) + 1);
	endfunction

	function automatic int ring_level();
		if (wr_pos == rd_pos)
			return ring_empty ? 0 : brf_pkg::DEPTH;
		return (int'(wr_pos) - int'(rd_pos) + brf_pkg::DEPTH) % brf_pkg::DEPTH;
	endfunction

	function automatic void ring_drain(int n);
		int k;
		brf_pkg::byte_t b;
		k = 0;
		while (!ring_empty && k < n) begin
			k++;
			b = ring_mem[rd_pos];
			rd_pos = ring_next(rd_pos);
			if (rd_pos == wr_pos)
				ring_empty = 1'b1;
			step_resp.push_back('{brf_pkg::STS_BYTE, b, 7'd0, ring_empty || (k == n)});
		end
	endfunction

	function automatic void ring_apply(brf_pkg::code_t cmd, brf_pkg::byte_t wb,
			brf_pkg::cnt_t cnt);
		int n;
		int lvl;
		brf_pkg::idx_t p;
		step_resp.delete();
		case (cmd)
			brf_pkg::CMD_WRITE: begin
				if (!ring_empty && wr_pos == rd_pos) begin
					step_resp.push_back('{brf_pkg::STS_WR_FULL, 8'h00, 7'd0, 1'b1});
				end else begin
					ring_mem[wr_pos] = wb;
					wr_pos = ring_next(wr_pos);
					ring_empty = 1'b0;
					step_resp.push_back('{brf_pkg::STS_WR_OK, 8'h00, 7'd0, 1'b1});
				end
			end
			brf_pkg::CMD_READ: begin
				ring_drain(int'(cnt));
			end
			brf_pkg::CMD_LINE: begin
				lvl = ring_level();
				n = lvl;
				p = rd_pos;
				for (int i = 0; i < lvl; i++) begin
					if (ring_mem[p] == delim) begin
						n = i + 1;
						break;
					end
					p = ring_next(p);
				end
				ring_drain(n);
			end
			default: begin
				step_resp.push_back('{brf_pkg::STS_FREE, 8'h00,
					brf_pkg::cnt_t'(brf_pkg::DEPTH - ring_level()), 1'b1});
			end
		endcase
	endfunction

	// model update and response check
	always @(posedge clk) begin
		brf_pkg::res_t want;
		brf_pkg::res_t got;
		if (arst_n) begin
			if (cfg_wr_en)
				delim = cfg_wr_data;
			if (s_tvalid && s_tready) begin
				ring_apply(brf_pkg::code_t'(s_tuser), s_tdata[7:0], s_tdata[14:8]);
				if (tab_n == PRED) begin
					foreach (step_resp[j])
						pending_resp.push_back(step_resp[j]);
				end else if (tab_n == 1) begin
					pending_resp.push_back(tab_res);
				end
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[7:0], m_tdata[14:8], m_tlast};
				if (pending_resp.size() == 0) begin
					$display("%0t: unexpected response sts=%0d byte=%h free=%0d last=%b",
						$time, got.status, got.read_byte, got.free_space, got.last);
					err_cnt++;
				end else begin
					want = pending_resp.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch exp sts=%0d byte=%h free=%0d last=%b",
							$time, want.status, want.read_byte, want.free_space, want.last);
						$display("%0t:          got sts=%0d byte=%h free=%0d last=%b",
							$time, got.status, got.read_byte, got.free_space, got.last);
						err_cnt++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// response side: random stalls, one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				hold_req <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic send(brf_pkg::code_t cmd, brf_pkg::byte_t wb, brf_pkg::cnt_t cnt,
			int exp_n, brf_pkg::res_t exp_res);
		if (!no_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, cnt, wb};
		s_tuser  <= cmd;
		tab_n    <= exp_n;
		tab_res  <= exp_res;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_resp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_delimiter(brf_pkg::byte_t v);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic brf_pkg::cnt_t rand_count();
		return ($urandom_range(0, 7) == 0) ? brf_pkg::cnt_t'($urandom_range(0, 64))
			: brf_pkg::cnt_t'($urandom_range(0, 6));
	endfunction

	function automatic brf_pkg::byte_t rand_byte(brf_pkg::byte_t d);
		return ($urandom_range(0, 4) == 0) ? d : brf_pkg::byte_t'($urandom_range(0, 255));
	endfunction

	task automatic rand_req(brf_pkg::byte_t d);
		int r;
		brf_pkg::code_t cmd;
		r = $urandom_range(0, 99);
		if (r < 55)
			cmd = brf_pkg::CMD_WRITE;
		else if (r < 68)
			cmd = brf_pkg::CMD_READ;
		else if (r < 88)
			cmd = brf_pkg::CMD_LINE;
		else
			cmd = brf_pkg::CMD_QUERY;
		send(cmd, rand_byte(d), rand_count(), PRED, '0);
	endtask

	initial begin
		int n;
		int k;
		brf_pkg::byte_t d;
		dir_tab = '{
			'{brf_pkg::CMD_QUERY, 8'h00, 7'd0,  1,    '{brf_pkg::STS_FREE, 8'h00, 7'd64, 1'b1}},
			'{brf_pkg::CMD_READ,  8'h00, 7'd5,  0,    '0},
			'{brf_pkg::CMD_LINE,  8'h00, 7'd0,  0,    '0},
			'{brf_pkg::CMD_WRITE, 8'h00, 7'd64, 1,    '{brf_pkg::STS_WR_OK, 8'h00, 7'd0, 1'b1}},
			'{brf_pkg::CMD_WRITE, 8'hFF, 7'd0,  1,    '{brf_pkg::STS_WR_OK, 8'h00, 7'd0, 1'b1}},
			'{brf_pkg::CMD_WRITE, 8'h0A, 7'd63, 1,    '{brf_pkg::STS_WR_OK, 8'h00, 7'd0, 1'b1}},
			'{brf_pkg::CMD_WRITE, 8'h55, 7'd1,  1,    '{brf_pkg::STS_WR_OK, 8'h00, 7'd0, 1'b1}},
			'{brf_pkg::CMD_QUERY, 8'hFF, 7'd64, PRED, '0},
			'{brf_pkg::CMD_READ,  8'hAA, 7'd0,  0,    '0},
			'{brf_pkg::CMD_LINE,  8'h0A, 7'd64, PRED, '0},
			'{brf_pkg::CMD_READ,  8'h00, 7'd64, PRED, '0},
			'{brf_pkg::CMD_WRITE, 8'hAA, 7'd0,  PRED, '0},
			'{brf_pkg::CMD_WRITE, 8'h01, 7'd0,  PRED, '0},
			'{brf_pkg::CMD_WRITE, 8'h0A, 7'd0,  PRED, '0},
			'{brf_pkg::CMD_WRITE, 8'h0A, 7'd0,  PRED, '0},
			'{brf_pkg::CMD_LINE,  8'h00, 7'd0,  PRED, '0},
			'{brf_pkg::CMD_LINE,  8'h00, 7'd0,  PRED, '0},
			'{brf_pkg::CMD_LINE,  8'h00, 7'd0,  0,    '0},
			'{brf_pkg::CMD_WRITE, 8'h80, 7'd0,  PRED, '0},
			'{brf_pkg::CMD_WRITE, 8'h7F, 7'd0,  PRED, '0},
			'{brf_pkg::CMD_LINE,  8'h00, 7'd0,  PRED, '0},
			'{brf_pkg::CMD_WRITE, 8'h3C, 7'd0,  PRED, '0},
			'{brf_pkg::CMD_READ,  8'h00, 7'd1,  PRED, '0},
			'{brf_pkg::CMD_QUERY, 8'h00, 7'd0,  1,    '{brf_pkg::STS_FREE, 8'h00, 7'd64, 1'b1}}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_delimiter(8'h0A);

		for (int r = 0; r < N_DIR; r++)
			send(dir_tab[r].cmd, dir_tab[r].wr_byte, dir_tab[r].count,
				dir_tab[r].exp_n, dir_tab[r].exp_res);

		// fill past full, starting with a long hold on the responses
		settle();
		hold_req <= 1'b1;
		for (int r = 0; r < 66; r++)
			send(brf_pkg::CMD_WRITE, rand_byte(8'h0A), rand_count(), PRED, '0);
		send(brf_pkg::CMD_QUERY, 8'h00, 7'd0, PRED, '0);
		send(brf_pkg::CMD_LINE, 8'h00, 7'd0, PRED, '0);
		send(brf_pkg::CMD_WRITE, 8'h0A, 7'd0, PRED, '0);
		send(brf_pkg::CMD_READ, 8'h00, 7'd64, PRED, '0);
		send(brf_pkg::CMD_QUERY, 8'h00, 7'd0, PRED, '0);

		for (int ph = 0; ph < 3; ph++) begin
			d = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF
				: brf_pkg::byte_t'($urandom_range(0, 255));
			set_delimiter(d);
			no_gaps = (ph == 2);
			n = 0;
			while (n < 8) begin
				if ($urandom_range(0, 9) < 3) begin
					k = $urandom_range(1, 8);
					for (int j = 0; j < k; j++)
						send(brf_pkg::CMD_WRITE,
							(j == k - 1) ? d : brf_pkg::byte_t'($urandom_range(0, 255)),
							rand_count(), PRED, '0);
					send(brf_pkg::CMD_LINE, brf_pkg::byte_t'($urandom_range(0, 255)),
						rand_count(), PRED, '0);
					n += k + 1;
				end else begin
					rand_req(d);
					n++;
				end
			end
		end

		settle();
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
src/brf_pkg.sv
src/brf_ram.sv
src/brf_out.sv
src/byte_ring_fifo_with_line_read_core.sv
bench/tb_byte_ring_fifo_with_line_read_core.sv
